// ===== rtl/u8v_pkg.sv =====
// Package for the UTF-8 stream validator: status codes, byte-range constants
// and the state and result records shared by the step logic and the top level.
// No dependencies.
package u8v_pkg;

	localparam int unsigned CpW = 21;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NUL      = 3'd1,
		ST_BAD_LEAD = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_BAD_CONT = 3'd4,
		ST_BAD_CP   = 3'd5
	} status_t;

	localparam logic [7:0] LEAD2_LO  = 8'hc2;
	localparam logic [7:0] LEAD2_HI  = 8'hdf;
	localparam logic [7:0] LEAD3_LO  = 8'he0;
	localparam logic [7:0] LEAD3_HI  = 8'hef;
	localparam logic [7:0] LEAD4_LO  = 8'hf0;
	localparam logic [7:0] LEAD4_HI  = 8'hf4;
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] ASCII_TOP = 8'h80;

	localparam logic [CpW-1:0] CP_MAX     = 21'h10ffff;
	localparam logic [CpW-1:0] SURR_LO    = 21'h00d800;
	localparam logic [CpW-1:0] SURR_HI    = 21'h00dfff;
	localparam logic [CpW-1:0] MIN_LEN2   = 21'h000080;
	localparam logic [CpW-1:0] MIN_LEN3   = 21'h000800;
	localparam logic [CpW-1:0] MIN_LEN4   = 21'h010000;

	typedef struct packed {
		logic [1:0]     bytes_left;
		logic [1:0]     seq_length;
		logic [CpW-1:0] code_accum;
		logic           pend_bad;
		status_t        err;
	} dec_state_t;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           code_ready;
		status_t        status;
		logic           string_end;
	} dec_result_t;

endpackage

// ===== rtl/u8v_if.sv =====
// Valid/ready channel interfaces for the UTF-8 stream validator: the byte
// channel and the decoded-result channel. Depends on u8v_pkg.
interface u8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_req;
	logic       last;

	modport source (output valid, output byte_req, output last, input ready);
	modport sink   (input valid, input byte_req, input last, output ready);
endinterface

interface u8v_code_if;
	logic                          valid;
	logic                          ready;
	logic [u8v_pkg::CpW-1:0]       code_point;
	logic                          code_ready;
	u8v_pkg::status_t              status;
	logic                          string_end;

	modport source (output valid, output code_point, output code_ready, output status,
		output string_end, input ready);
	modport sink   (input valid, input code_point, input code_ready, input status,
		input string_end, output ready);
endinterface

// ===== rtl/utf8_stream_validator.sv =====
// Top level of the UTF-8 stream validator: state register, result register
// and handshake. Depends on u8v_pkg, u8v_if and u8v_step.
//
// Takes one byte per cycle on the byte channel while the sink keeps up and
// returns exactly one result per byte in the cycle after acceptance, holding
// the decoded scalar (with code_ready) and the running status; on the byte
// marked last the status is the verdict for the whole string and all decoder
// state clears. Sustained rate is one byte per clock: the decoder state is a
// single register, and the result register accepts a new byte whenever it
// is empty or its current result is being taken.
module utf8_stream_validator (
	input logic                clk,
	input logic                arst_n,
	u8v_byte_if.sink           bytes,
	u8v_code_if.source         codes
);

	u8v_pkg::dec_state_t   state_q;
	u8v_pkg::dec_state_t   state_nxt;
	u8v_pkg::dec_result_t  res;
	u8v_pkg::dec_result_t  res_q;
	logic                  out_valid_q;
	logic                  accept;

	assign bytes.ready = !out_valid_q || codes.ready;
	assign accept      = bytes.valid && bytes.ready;

	u8v_step u_step (
		.cur      (state_q),
		.byte_req (bytes.byte_req),
		.last     (bytes.last),
		.nxt      (state_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (codes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign codes.valid      = out_valid_q;
	assign codes.code_point = res_q.code_point;
	assign codes.code_ready = res_q.code_ready;
	assign codes.status     = res_q.status;
	assign codes.string_end = res_q.string_end;

	a_ready_ok: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && codes.code_ready |-> codes.status == u8v_pkg::ST_OK)
		else $error("scalar delivered with an error status");

	a_ready_range: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && codes.code_ready |-> codes.code_point <= u8v_pkg::CP_MAX
			&& codes.code_point != 21'd0)
		else $error("delivered scalar out of range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bytes.last |=> state_q.bytes_left == 2'd0
			&& state_q.err == u8v_pkg::ST_OK)
		else $error("state not cleared after last byte");

	a_left_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_left <= state_q.seq_length)
		else $error("more continuations pending than sequence length");

	a_end_echo: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> codes.valid && codes.string_end == $past(bytes.last))
		else $error("result missing or end flag lost");

endmodule

// ===== rtl/u8v_step.sv =====
// Next-state and result logic for one byte of the UTF-8 stream validator.
// Purely combinational; depends on u8v_pkg.
module u8v_step (
	input  u8v_pkg::dec_state_t  cur,
	input  logic [7:0]           byte_req,
	input  logic                 last,
	output u8v_pkg::dec_state_t  nxt,
	output u8v_pkg::dec_result_t res
);

	logic [1:0]                lead_n;
	logic [4:0]                lead_bits;
	logic                      pend;
	logic [u8v_pkg::CpW-1:0]   acc;
	logic [1:0]                left;
	logic [u8v_pkg::CpW-1:0]   min_cp;
	logic                      cp_ok;
	u8v_pkg::dec_state_t       upd;

	always_comb begin
		if (byte_req >= u8v_pkg::LEAD2_LO && byte_req <= u8v_pkg::LEAD2_HI) begin
			lead_n = 2'd1;
		end else if (byte_req >= u8v_pkg::LEAD3_LO && byte_req <= u8v_pkg::LEAD3_HI) begin
			lead_n = 2'd2;
		end else if (byte_req >= u8v_pkg::LEAD4_LO && byte_req <= u8v_pkg::LEAD4_HI) begin
			lead_n = 2'd3;
		end else begin
			lead_n = 2'd0;
		end
	end

	// payload bits of the lead byte shrink as the sequence grows
	always_comb begin
		case (lead_n)
			2'd1:    lead_bits = byte_req[4:0];
			2'd2:    lead_bits = {1'b0, byte_req[3:0]};
			2'd3:    lead_bits = {2'b00, byte_req[2:0]};
			default: lead_bits = '0;
		endcase
	end

	always_comb begin
		case (cur.seq_length)
			2'd1:    min_cp = u8v_pkg::MIN_LEN2;
			2'd2:    min_cp = u8v_pkg::MIN_LEN3;
			default: min_cp = u8v_pkg::MIN_LEN4;
		endcase
	end

	assign pend  = cur.pend_bad | ((byte_req & u8v_pkg::CONT_MASK) != u8v_pkg::CONT_TAG);
	assign acc   = {cur.code_accum[u8v_pkg::CpW-7:0], byte_req[5:0]};
	assign left  = cur.bytes_left - 2'd1;
	assign cp_ok = (acc >= min_cp) && (acc <= u8v_pkg::CP_MAX)
		&& !((acc >= u8v_pkg::SURR_LO) && (acc <= u8v_pkg::SURR_HI));

	always_comb begin
		upd = cur;
		res.code_point = '0;
		res.code_ready = 1'b0;
		if (cur.err == u8v_pkg::ST_OK) begin
			if (cur.bytes_left == 2'd0) begin
				if (byte_req < u8v_pkg::ASCII_TOP) begin
					if (byte_req == 8'd0) begin
						upd.err = u8v_pkg::ST_NUL;
					end else begin
						res.code_point = u8v_pkg::CpW'(byte_req);
						res.code_ready = 1'b1;
					end
				end else if (lead_n == 2'd0) begin
					upd.err = u8v_pkg::ST_BAD_LEAD;
				end else begin
					upd.bytes_left = lead_n;
					upd.seq_length = lead_n;
					upd.code_accum = u8v_pkg::CpW'(lead_bits);
					upd.pend_bad   = 1'b0;
					if (last) begin
						upd.err = u8v_pkg::ST_TRUNC;
					end
				end
			end else begin
				upd.code_accum = acc;
				upd.bytes_left = left;
				upd.pend_bad   = pend;
				if (left == 2'd0) begin
					// sequence complete: a held bad continuation wins over range checks
					if (pend) begin
						upd.err = u8v_pkg::ST_BAD_CONT;
					end else if (!cp_ok) begin
						upd.err = u8v_pkg::ST_BAD_CP;
					end else begin
						res.code_point = acc;
						res.code_ready = 1'b1;
					end
					upd.pend_bad = 1'b0;
				end else if (last) begin
					upd.err = u8v_pkg::ST_TRUNC;
				end
			end
		end
		res.status     = upd.err;
		res.string_end = last;
		// drop all state at the end of the string
		nxt = last ? '0 : upd;
	end

endmodule

// ===== test/tb_utf8_stream_validator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_validator: random-paced byte requests
// in, decoded results out, checked against an in-bench decoder model.
// Depends on u8v_pkg, u8v_if and the utf8_stream_validator RTL.
module tb_utf8_stream_validator;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_BYTES  = 1500;
	localparam int HOLD_LEN    = 60;

	logic clk;
	logic arst_n;

	u8v_byte_if byte_ch ();
	u8v_code_if code_ch ();

	utf8_stream_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch.sink),
		.codes  (code_ch.source)
	);

	// decoder model state
	logic [1:0]              exp_left;
	logic [1:0]              exp_total;
	logic [u8v_pkg::CpW-1:0] exp_accum;
	logic                    exp_bad_cont;
	u8v_pkg::status_t        exp_err;

	u8v_pkg::dec_result_t expected_codes[$];
	logic [7:0]           text_q[$];

	int  fail_count;
	int  cycle_count;
	int  bytes_sent;
	int  strings_sent;
	int  results_seen;
	int  scalars_seen;
	int  rejected_seen;
	int  hold_cycles;
	int  held_total;
	bit  idle_on;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			expected_codes.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_fail(input string msg);
		$display("[%0t] %s", $time, msg);
		fail_count++;
	endtask

	function automatic void clear_decoder();
		exp_left     = '0;
		exp_total    = '0;
		exp_accum    = '0;
		exp_bad_cont = 1'b0;
		exp_err      = u8v_pkg::ST_OK;
	endfunction

	function automatic bit scalar_legal(input logic [u8v_pkg::CpW-1:0] v,
		input logic [1:0] n);
		logic [u8v_pkg::CpW-1:0] floor_cp;
		floor_cp = (n == 2'd1) ? u8v_pkg::MIN_LEN2 :
			(n == 2'd2) ? u8v_pkg::MIN_LEN3 : u8v_pkg::MIN_LEN4;
		if (v < floor_cp || v > u8v_pkg::CP_MAX)
			return 1'b0;
		if (v >= u8v_pkg::SURR_LO && v <= u8v_pkg::SURR_HI)
			return 1'b0;
		return 1'b1;
	endfunction

	// Advance the decoder model by one byte and return the result it should produce.
	function automatic u8v_pkg::dec_result_t decode_byte(input logic [7:0] b, input logic l);
		u8v_pkg::dec_result_t r;
		logic [1:0]           n;
		r = '0;
		if (exp_err == u8v_pkg::ST_OK) begin
			if (exp_left == 2'd0) begin
				if (b < u8v_pkg::ASCII_TOP) begin
					if (b == 8'h00)
						exp_err = u8v_pkg::ST_NUL;
					else begin
						r.code_point = {13'd0, b};
						r.code_ready = 1'b1;
					end
				end else begin
					n = 2'd0;
					if (b >= u8v_pkg::LEAD2_LO && b <= u8v_pkg::LEAD2_HI)
						n = 2'd1;
					else if (b >= u8v_pkg::LEAD3_LO && b <= u8v_pkg::LEAD3_HI)
						n = 2'd2;
					else if (b >= u8v_pkg::LEAD4_LO && b <= u8v_pkg::LEAD4_HI)
						n = 2'd3;
					if (n == 2'd0)
						exp_err = u8v_pkg::ST_BAD_LEAD;
					else begin
						exp_left     = n;
						exp_total    = n;
						exp_accum    = {13'd0, b & (8'hff >> (int'(n) + 2))};
						exp_bad_cont = 1'b0;
						if (l)
							exp_err = u8v_pkg::ST_TRUNC;
					end
				end
			end else begin
				// a bad continuation still counts toward the sequence length
				if ((b & u8v_pkg::CONT_MASK) != u8v_pkg::CONT_TAG)
					exp_bad_cont = 1'b1;
				exp_accum = {exp_accum[u8v_pkg::CpW-7:0], b[5:0]};
				exp_left  = exp_left - 2'd1;
				if (exp_left == 2'd0) begin
					if (exp_bad_cont)
						exp_err = u8v_pkg::ST_BAD_CONT;
					else if (!scalar_legal(exp_accum, exp_total))
						exp_err = u8v_pkg::ST_BAD_CP;
					else begin
						r.code_point = exp_accum;
						r.code_ready = 1'b1;
					end
					exp_bad_cont = 1'b0;
				end else if (l) begin
					exp_err = u8v_pkg::ST_TRUNC;
				end
			end
		end
		r.status     = exp_err;
		r.string_end = l;
		if (l)
			clear_decoder();
		return r;
	endfunction

	// Offer one byte request, hold it until accepted, then log the expected result.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		u8v_pkg::dec_result_t want_r;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid    <= 1'b1;
		byte_ch.byte_req <= b;
		byte_ch.last     <= l;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		want_r = decode_byte(b, l);
		expected_codes = {expected_codes, want_r};
		bytes_sent++;
	endtask

	task automatic append_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
		strings_sent++;
	endtask

	task automatic push_scalar(input logic [u8v_pkg::CpW-1:0] cp);
		if (cp < 21'h80)
			append_byte(cp[7:0]);
		else if (cp < 21'h800) begin
			append_byte({3'b110, cp[10:6]});
			append_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			append_byte({4'b1110, cp[15:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end else begin
			append_byte({5'b11110, cp[20:18]});
			append_byte({2'b10, cp[17:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end
	endtask

	task automatic push_legal_char();
		logic [u8v_pkg::CpW-1:0] cp;
		case ($urandom_range(0, 3))
			0: cp = 21'($urandom_range(1, 'h7f));
			1: cp = 21'($urandom_range('h80, 'h7ff));
			2: begin
				cp = 21'($urandom_range('h800, 'hffff));
				if (cp >= u8v_pkg::SURR_LO && cp <= u8v_pkg::SURR_HI)
					cp = cp + 21'h800;
			end
			default: cp = 21'($urandom_range('h10000, 'h10ffff));
		endcase
		push_scalar(cp);
	endtask

	// Any lead and continuation payload: overlongs, surrogates, out-of-range values
	// and the 0xf5-0xf7 leads fall out of this naturally.
	task automatic push_raw_form();
		int n;
		logic [7:0] lead;
		n = $urandom_range(1, 3);
		lead = 8'($urandom_range(0, 255));
		case (n)
			1: lead = {3'b110, lead[4:0]};
			2: lead = {4'b1110, lead[3:0]};
			default: lead = {5'b11110, lead[2:0]};
		endcase
		append_byte(lead);
		repeat (n) append_byte({2'b10, 6'($urandom_range(0, 63))});
	endtask

	task automatic test_directed();
		text_q = '{8'h01, 8'hc2, 8'h80, 8'h7f};
		send_text();
		text_q = '{8'h00};
		send_text();
		text_q = '{8'hff};
		send_text();
		text_q = '{8'he0, 8'h80, 8'h80};
		send_text();
		text_q = '{8'hed, 8'ha0, 8'h80};
		send_text();
		text_q = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_text();
		text_q = '{8'hf4, 8'h90, 8'h80, 8'h80};
		send_text();
		// bad continuation, then later bytes ignored; 0x80 would be a bad lead
		text_q = '{8'hc2, 8'h41, 8'h80};
		send_text();
		text_q = '{8'he0};
		send_text();
		// truncation wins over an earlier bad continuation
		text_q = '{8'hf0, 8'h00};
		send_text();
	endtask

	task automatic test_backpressure();
		idle_on     = 1'b0;
		hold_cycles = HOLD_LEN;
		repeat (2) begin
			repeat (11) append_byte(8'($urandom_range('h20, 'h7e)));
			push_legal_char();
			send_text();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random_strings();
		int kind;
		int pick;
		int n_chars;
		int tail_len;
		int start_sent;
		start_sent = bytes_sent;
		while (bytes_sent - start_sent < RAND_BYTES) begin
			if ($urandom_range(0, 19) == 0)
				idle_on = !idle_on;
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
			end else begin
				n_chars  = $urandom_range(1, 8);
				tail_len = 0;
				for (int c = 0; c < n_chars; c++) begin
					tail_len = text_q.size();
					pick = $urandom_range(0, 99);
					if (pick < 72)
						push_legal_char();
					else if (pick < 84)
						push_raw_form();
					else if (pick < 88)
						append_byte($urandom_range(0, 1) ? 8'h00 :
							8'($urandom_range('h80, 'hff)));
					else begin
						// corrupt one trailing byte of a multibyte character
						push_scalar(21'($urandom_range('h80, 'hd7ff)));
						text_q[$urandom_range(tail_len + 1, text_q.size() - 1)] =
							8'($urandom_range(0, 255));
					end
					tail_len = text_q.size() - tail_len;
				end
				// cut the string inside its final character now and then
				if (tail_len > 1 && $urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, tail_len - 1)) void'(text_q.pop_back());
			end
			send_text();
		end
		idle_on = 1'b1;
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		u8v_pkg::dec_result_t want;
		if (arst_n && code_ch.valid && code_ch.ready) begin
			if (expected_codes.size() == 0)
				report_fail("result arrived with no request outstanding");
			else begin
				want = expected_codes.pop_front();
				if (code_ch.code_point !== want.code_point)
					report_fail($sformatf("result %0d code_point 0x%0h, want 0x%0h",
						results_seen, code_ch.code_point, want.code_point));
				if (code_ch.code_ready !== want.code_ready)
					report_fail($sformatf("result %0d code_ready %b, want %b",
						results_seen, code_ch.code_ready, want.code_ready));
				if (code_ch.status !== want.status)
					report_fail($sformatf("result %0d status %0d, want %0d",
						results_seen, code_ch.status, want.status));
				if (code_ch.string_end !== want.string_end)
					report_fail($sformatf("result %0d string_end %b, want %b",
						results_seen, code_ch.string_end, want.string_end));
				if (want.code_ready)
					scalars_seen++;
				if (want.string_end && want.status != u8v_pkg::ST_OK)
					rejected_seen++;
				results_seen++;
			end
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin : code_sink
		int stall;
		code_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
				held_total += stall;
			end else begin
				stall = idle_on ? $urandom_range(0, 11) : 0;
			end
			if (stall > 0) begin
				code_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			code_ch.ready <= 1'b1;
			@(posedge clk);
			while (!code_ch.valid) @(posedge clk);
		end
	end

	initial begin
		arst_n           = 1'b0;
		byte_ch.valid    = 1'b0;
		byte_ch.byte_req = 8'h00;
		byte_ch.last     = 1'b0;
		fail_count       = 0;
		cycle_count      = 0;
		bytes_sent       = 0;
		strings_sent     = 0;
		results_seen     = 0;
		scalars_seen     = 0;
		rejected_seen    = 0;
		hold_cycles      = 0;
		held_total       = 0;
		idle_on          = 1'b1;
		clear_decoder();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_strings();

		byte_ch.valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		$display("Sent %0d bytes in %0d strings; checked %0d results, %0d scalars decoded,",
			bytes_sent, strings_sent, results_seen, scalars_seen);
		$display("%0d strings rejected; random pacing on both sides, %0d-cycle output hold.",
			rejected_seen, held_total);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
